@@ hdl/mpvl_pkg.sv @@
// Shared types, constants and vendor ROM for the MAC prefix vendor lookup.
package mpvl_pkg;

	localparam int TableDepthDefault    = 4096;
	localparam int BuiltinEntriesDefault = 15;
	localparam int RomSize              = 15;
	localparam int PrefixW              = 24;
	localparam int CountW               = 13;
	localparam int SlotW                = 12;
	localparam int LocalAdminBit        = 17;

	// Request codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_NOT_FOUND = 2'd0;
	localparam logic [1:0] KIND_RANDOM    = 2'd1;
	localparam logic [1:0] KIND_BUILTIN   = 2'd2;
	localparam logic [1:0] KIND_TABLE     = 2'd3;

	// Built-in vendor prefixes, first byte most significant
	localparam logic [PrefixW-1:0] VENDOR_ROM [RomSize] = '{
		24'h005056, 24'h000C29, 24'h000569, 24'h001C14, 24'h00155D,
		24'h080027, 24'h0A0027, 24'h525400, 24'h00163E, 24'hB827EB,
		24'hDCA632, 24'hE45F01, 24'h28CDC1, 24'h2CCF67, 24'hD83ADD
	};

	typedef struct packed {
		logic               req_type;
		logic [SlotW-1:0]   entry_index;
		logic [PrefixW-1:0] entry_prefix;
		logic [PrefixW-1:0] query_prefix;
	} req_t;

	typedef struct packed {
		logic [1:0]       match_kind;
		logic [3:0]       builtin_index;
		logic [SlotW-1:0] record_index;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_we;
		logic capture;
		logic init;
		logic probe;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic check_done;
		logic search_done;
	} dp_status_t;

endpackage

@@ hdl/mpvl_ctrl.sv @@
// Controller state machine for the MAC prefix vendor lookup.
module mpvl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   req_type,
	input  mpvl_pkg::dp_status_t   status,
	output mpvl_pkg::ctrl_cmd_t    cmd,
	output logic                   busy
);
	import mpvl_pkg::*;

	state_t state_q;
	state_t state_n;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Decode next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == REQ_LOOKUP) begin
						cmd.capture = 1'b1;
						state_n     = ST_CHECK;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				cmd.init = 1'b1;
				if (status.check_done) begin
					state_n = ST_IDLE;
				end else begin
					state_n = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.probe = 1'b1;
				if (status.search_done) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/mpvl_datapath.sv @@
// Datapath: prefix table memory, built-in match, binary search and result register.
module mpvl_datapath #(
	parameter int TABLE_DEPTH     = mpvl_pkg::TableDepthDefault,
	parameter int BUILTIN_ENTRIES = mpvl_pkg::BuiltinEntriesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpvl_pkg::req_t                req,
	input  mpvl_pkg::ctrl_cmd_t           cmd,
	input  logic                          cfg_we,
	input  logic [mpvl_pkg::CountW-1:0]   cfg_wdata,
	output mpvl_pkg::dp_status_t          status,
	output logic                          done,
	output mpvl_pkg::res_t                result
);
	import mpvl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [PrefixW-1:0] mem [TABLE_DEPTH];
	logic [PrefixW-1:0] rdata_q;
	logic [CountW-1:0]  count_q;
	logic [PrefixW-1:0] query_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      end_q;
	logic [CW-1:0]      mid_q;
	logic               done_q;
	res_t               result_q;

	logic [31:0]        wr_slot_wide;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [CW-1:0]      n_clamped;
	logic               rom_hit;
	logic [3:0]         rom_idx;
	logic [CW-1:0]      lo_n;
	logic [CW-1:0]      end_n;
	logic [CW-1:0]      span;
	logic [CW-1:0]      mid_n;
	logic               rd_en;
	logic               res_en;
	res_t               res_n;
	logic [31:0]        mid_wide;

	// Hold the table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Drop loads to slots beyond the table
	assign wr_slot_wide = 32'(req.entry_index);
	assign wr_en        = cmd.load_we && (wr_slot_wide < 32'(TABLE_DEPTH));
	assign wr_addr      = wr_slot_wide[AW-1:0];

	// Clamp the search span to the table depth
	assign n_clamped = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

	// Match the built-in prefixes, lowest index wins
	always_comb begin
		rom_hit = 1'b0;
		rom_idx = '0;
		for (int i = RomSize - 1; i >= 0; i--) begin
			if ((i < BUILTIN_ENTRIES) && (VENDOR_ROM[i] == query_q)) begin
				rom_hit = 1'b1;
				rom_idx = 4'(i);
			end
		end
	end

	// Decide the check step and each probe
	always_comb begin
		lo_n               = lo_q;
		end_n              = end_q;
		rd_en              = 1'b0;
		res_en             = 1'b0;
		res_n              = '0;
		status.check_done  = 1'b0;
		status.search_done = 1'b0;
		mid_wide           = 32'(mid_q);
		if (cmd.init) begin
			lo_n  = '0;
			end_n = n_clamped;
			if (query_q[LocalAdminBit]) begin
				status.check_done = 1'b1;
				res_n.match_kind  = KIND_RANDOM;
			end else if (rom_hit) begin
				status.check_done   = 1'b1;
				res_n.match_kind    = KIND_BUILTIN;
				res_n.builtin_index = rom_idx;
			end else if (n_clamped == '0) begin
				status.check_done = 1'b1;
				res_n.match_kind  = KIND_NOT_FOUND;
			end
			res_en = status.check_done;
			rd_en  = !status.check_done;
		end else if (cmd.probe) begin
			if (rdata_q == query_q) begin
				status.search_done = 1'b1;
				res_n.match_kind   = KIND_TABLE;
				res_n.record_index = mid_wide[SlotW-1:0];
			end else begin
				if (rdata_q < query_q) begin
					lo_n = mid_q + CW'(1);
				end else begin
					end_n = mid_q;
				end
				if (lo_n >= end_n) begin
					status.search_done = 1'b1;
					res_n.match_kind   = KIND_NOT_FOUND;
				end
			end
			res_en = status.search_done;
			rd_en  = !status.search_done;
		end
		span  = end_n - lo_n - CW'(1);
		mid_n = lo_n + (span >> 1);
	end

	// Write loads and read the next probe
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.entry_prefix;
		end
		if (rd_en) begin
			rdata_q <= mem[mid_n[AW-1:0]];
		end
	end

	// Advance the search window
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			query_q <= req.query_prefix;
		end
		if (cmd.init || cmd.probe) begin
			lo_q  <= lo_n;
			end_q <= end_n;
			mid_q <= mid_n;
		end
		if (res_en) begin
			result_q <= res_n;
		end
	end

	// Pulse the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_en;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hdl/mac_prefix_vendor_lookup.sv @@
// Top level of the MAC prefix vendor lookup: controller plus datapath.
//
// Classifies 24-bit MAC vendor prefixes. Pulse start with a request while busy is
// low. A load request (req_type 0) writes one prefix into the sorted table and
// returns nothing; busy stays low, so a new request may follow in the next cycle.
// A lookup request raises busy and returns one result on result, marked by done
// for exactly one cycle; the receiver cannot stall it, so capture it when done is
// high. A locally administered or built-in prefix, or an empty table, is decided
// in the check state with no table read. Otherwise the table search makes one
// probe per cycle through the single read port of the table memory, at most
// ceil(log2(n + 1)) probes for n entries, so 13 probes at 4096 entries.
// Write cfg_wdata (entry count) with cfg_we only while no lookup is in flight.
module mac_prefix_vendor_lookup #(
	parameter int TABLE_DEPTH     = mpvl_pkg::TableDepthDefault,
	parameter int BUILTIN_ENTRIES = mpvl_pkg::BuiltinEntriesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  mpvl_pkg::req_t                req,
	output logic                          done,
	output mpvl_pkg::res_t                result,
	input  logic                          cfg_we,
	input  logic [mpvl_pkg::CountW-1:0]   cfg_wdata
);
	import mpvl_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence each request
	mpvl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Store the table and run the search
	mpvl_datapath #(
		.TABLE_DEPTH     (TABLE_DEPTH),
		.BUILTIN_ENTRIES (BUILTIN_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule
